>>> rtl/core/oets_pkg.sv
// Shared types and constants for the odd-even transposition sorter.
`default_nettype none

package oets_pkg;

  // Default number of cells in the chain and the fixed field widths.
  localparam int unsigned DefDepth  = 64;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned PositionW = 6;
  localparam int unsigned OutDataW  = 40;

  // What every cell does in a given cycle.
  typedef enum logic [1:0] {
    CellHold,
    CellLoad,
    CellSort,
    CellShift
  } cell_op_e;

  // Control word broadcast from the sequencer to the whole chain.
  typedef struct packed {
    cell_op_e op;
    logic     parity;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StLoad,
    StSort,
    StEmit
  } oets_state_e;

endpackage

`default_nettype wire

>>> rtl/core/oets_cell.sv
// One cell of the sorting chain: holds a single element and its valid bit.
`default_nettype none

module oets_cell #(
  parameter logic LowParity = 1'b0
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  oets_pkg::cell_ctrl_t          ctrl_i,
  input  wire  [oets_pkg::ValueW-1:0]   prev_val_i,
  input  wire                           prev_valid_i,
  input  wire  [oets_pkg::ValueW-1:0]   next_val_i,
  input  wire                           next_valid_i,
  output logic [oets_pkg::ValueW-1:0]   val_o,
  output logic                          valid_o,
  output logic                          swap_o
);
  import oets_pkg::*;

  logic [ValueW-1:0] val_q, val_d;
  logic              valid_q, valid_d;
  logic              is_lower;
  logic              take_next;
  logic              take_prev;

  // The cell is the lower member of its pair when its index parity matches the phase.
  assign is_lower  = (LowParity == ctrl_i.parity);
  assign take_next = is_lower && valid_q && next_valid_i &&
                     ($signed(val_q) > $signed(next_val_i));
  assign take_prev = !is_lower && valid_q && prev_valid_i &&
                     ($signed(prev_val_i) > $signed(val_q));

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    swap_o  = 1'b0;
    case (ctrl_i.op)
      CellLoad: begin
        val_d   = prev_val_i;
        valid_d = prev_valid_i;
      end
      CellShift: begin
        val_d   = next_val_i;
        valid_d = next_valid_i;
      end
      CellSort: begin
        if (take_next) begin
          val_d  = next_val_i;
          swap_o = 1'b1;
        end else if (take_prev) begin
          val_d = prev_val_i;
        end
      end
      default: begin
        val_d   = val_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

>>> rtl/core/oets_ctrl.sv
// Sequencer for the sorting chain: load, sort phases, and ordered emission.
`default_nettype none

module oets_ctrl #(
  parameter int unsigned Depth = oets_pkg::DefDepth
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_tvalid_i,
  input  wire                              s_tlast_i,
  output logic                             s_tready_o,
  output logic                             m_tvalid_o,
  input  wire                              m_tready_i,
  output logic                             m_tlast_o,
  output logic [oets_pkg::PositionW-1:0]   position_o,
  input  wire                              any_swap_i,
  output oets_pkg::cell_ctrl_t             ctrl_o
);
  import oets_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned PosW = $clog2(Depth);

  oets_state_e     state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            parity_q, parity_d;
  logic [1:0]      quiet_q, quiet_d;
  logic            has_room;
  logic            is_last;

  assign has_room = (fill_q < CntW'(Depth));
  assign is_last  = ((CntW'(pos_q) + CntW'(1)) == fill_q);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    pos_d      = pos_q;
    parity_d   = parity_q;
    quiet_d    = quiet_q;
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;
    ctrl_o.op     = CellHold;
    ctrl_o.parity = parity_q;
    case (state_q)
      StLoad: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          if (has_room) begin
            ctrl_o.op = CellLoad;
            fill_d    = fill_q + CntW'(1);
          end
          if (s_tlast_i) begin
            state_d  = StSort;
            parity_d = 1'b0;
            quiet_d  = 2'd0;
          end
        end
      end
      StSort: begin
        ctrl_o.op = CellSort;
        parity_d  = ~parity_q;
        if (any_swap_i) begin
          quiet_d = 2'd0;
        end else begin
          quiet_d = quiet_q + 2'd1;
          if (quiet_q == 2'd1) begin
            state_d = StEmit;
            pos_d   = '0;
          end
        end
      end
      StEmit: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          ctrl_o.op = CellShift;
          pos_d     = pos_q + PosW'(1);
          if (is_last) begin
            state_d  = StLoad;
            fill_d   = '0;
            parity_d = 1'b0;
            quiet_d  = 2'd0;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      fill_q   <= '0;
      pos_q    <= '0;
      parity_q <= 1'b0;
      quiet_q  <= 2'd0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      parity_q <= parity_d;
      quiet_q  <= quiet_d;
    end
  end

  assign m_tlast_o  = is_last;
  assign position_o = PositionW'(pos_q);

endmodule

`default_nettype wire

>>> rtl/core/odd_even_transposition_sorter_core.sv
// Top level of the odd-even transposition sorter: a chain of cells plus its sequencer.
`default_nettype none

// Channel   Direction  tdata (low bit up)                       tlast        tuser
// s_axis    in         value[31:0]                              last_item    -
// m_axis    out        sorted_value[31:0], position[37:32], 0s  last_result  -
//
// A block loads at one item per cycle into a chain of DEPTH cells, entering at
// cell 0 and shifting up. The sort then runs one compare-exchange phase per cycle
// across all pairs of the chain, alternating even and odd phases, and ends after
// two phases in a row without an exchange. Emission shifts the chain down one
// cell per accepted result, and holds while the receiver stalls. Input is not
// accepted during sort and emission. Reset clears all control and the valid bits.

module odd_even_transposition_sorter_core #(
  parameter int unsigned DEPTH = oets_pkg::DefDepth
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // value
  input  wire  [oets_pkg::ValueW-1:0]     s_axis_tdata_i,
  input  wire                             s_axis_tlast_i,
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // sorted_value, position, zero padding
  output logic [oets_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic                            m_axis_tlast_o,
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i
);
  import oets_pkg::*;

  cell_ctrl_t             ctrl;
  logic [ValueW-1:0]      cell_val   [DEPTH];
  logic                   cell_valid [DEPTH];
  logic [DEPTH-1:0]       cell_swap;
  logic [PositionW-1:0]   position;

  oets_ctrl #(
    .Depth (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tlast_i  (s_axis_tlast_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tlast_o  (m_axis_tlast_o),
    .position_o (position),
    .any_swap_i (|cell_swap),
    .ctrl_o     (ctrl)
  );

  // Cell 0 takes the incoming value on a load; its lower neighbor is never valid
  // during a sort. The top cell sees an empty neighbor above it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ValueW-1:0] prev_val;
    logic              prev_valid;
    logic [ValueW-1:0] next_val;
    logic              next_valid;

    if (i == 0) begin : g_first
      assign prev_val   = s_axis_tdata_i;
      assign prev_valid = (ctrl.op == CellLoad);
    end else begin : g_inner_lo
      assign prev_val   = cell_val[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign next_val   = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner_hi
      assign next_val   = cell_val[i+1];
      assign next_valid = cell_valid[i+1];
    end

    oets_cell #(
      .LowParity (1'(i % 2))
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_val_i   (prev_val),
      .prev_valid_i (prev_valid),
      .next_val_i   (next_val),
      .next_valid_i (next_valid),
      .val_o        (cell_val[i]),
      .valid_o      (cell_valid[i]),
      .swap_o       (cell_swap[i])
    );
  end

  // Results leave from cell 0; it holds steady until the item is taken.
  assign m_axis_tdata_o = {(OutDataW - ValueW - PositionW)'(0), position, cell_val[0]};

endmodule

`default_nettype wire
